// File: rtl/mhsq_pkg.sv
// ----------------------------------------------------------------------------
// mhsq_pkg
// Shared types, widths, register codes and the sine table function of the
// multi-harmonic synthesiser and quantiser.
// ----------------------------------------------------------------------------
package mhsq_pkg;

   localparam int MAX_HARMONICS_DEF  = 8;
   localparam int SINE_ADDR_BITS_DEF = 10;

   localparam int AMP_W      = 16;
   localparam int PHASE_W    = 32;
   localparam int HIDX_W     = 3;
   localparam int SAMPLE_W   = 20;
   localparam int CODE_W     = 16;
   localparam int SINE_W     = 16;
   localparam int HC_W       = 4;
   localparam int QB_W       = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int TBL_W      = AMP_W + 2 * PHASE_W;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_HARMONIC_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT_BITS     = 2'd1;

   // action codes of an input transaction
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   localparam logic [QB_W-1:0] QUANT_BITS_RESET = 5'd8;
   localparam logic [QB_W-1:0] QUANT_BITS_MAX   = 5'd16;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint          ONE_Q30     = 64'sd1073741824;

   typedef struct packed {
      logic               action;
      logic [HIDX_W-1:0]  harmonic_index;
      logic [AMP_W-1:0]   amplitude;
      logic [PHASE_W-1:0] phase_step;
      logic [PHASE_W-1:0] phase_offset;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [CODE_W-1:0]          code;
   } rsp_type;

   // one entry of the Q1.15 sine table, evaluated at elaboration only:
   // Taylor series in Q30 over the first quadrant, mirrored to the others
   function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned k,
                                                           input int unsigned addr_bits);
      int unsigned              qsh;
      int unsigned              quarter;
      int unsigned              q;
      int unsigned              r;
      int unsigned              m;
      longint unsigned          x;
      longint unsigned          x2;
      longint unsigned          term;
      longint                   s;
      longint unsigned          v;
      logic signed [SINE_W-1:0] res;
      qsh     = addr_bits - 2;
      quarter = 1 << qsh;
      q       = k >> qsh;
      r       = k & (quarter - 1);
      m       = (q == 0 || q == 2) ? r : quarter - r;
      x       = (64'(m) * HALF_PI_Q30 + (64'd1 << (qsh - 1))) >> qsh;
      x2      = (x * x) >> 30;
      term    = x;
      s       = longint'(x);
      term    = ((term * x2) >> 30) / 64'd6;
      s       = s - longint'(term);
      term    = ((term * x2) >> 30) / 64'd20;
      s       = s + longint'(term);
      term    = ((term * x2) >> 30) / 64'd42;
      s       = s - longint'(term);
      term    = ((term * x2) >> 30) / 64'd72;
      s       = s + longint'(term);
      term    = ((term * x2) >> 30) / 64'd110;
      s       = s - longint'(term);
      term    = ((term * x2) >> 30) / 64'd156;
      s       = s + longint'(term);
      term    = ((term * x2) >> 30) / 64'd210;
      s       = s - longint'(term);
      if (s < 0) s = 0;
      if (s > ONE_Q30) s = ONE_Q30;
      v   = (longint'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
      res = SINE_W'(v);
      if (q >= 2) res = -res;
      return res;
   endfunction

endpackage

// File: rtl/mhsq_ram.sv
// ----------------------------------------------------------------------------
// mhsq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mhsq_ram
   import mhsq_pkg::*;
#(
   parameter int WIDTH = PHASE_W,
   parameter int DEPTH = MAX_HARMONICS_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mhsq_sine_rom.sv
// ----------------------------------------------------------------------------
// mhsq_sine_rom
// Full-wave Q1.15 sine table with registered read, contents fixed at
// elaboration.
// ----------------------------------------------------------------------------
module mhsq_sine_rom
   import mhsq_pkg::*;
#(
   parameter int ADDR_BITS = SINE_ADDR_BITS_DEF
) (
   input  logic                     clock,
   input  logic [ADDR_BITS-1:0]     rd_addr,
   output logic signed [SINE_W-1:0] rd_data
);

   localparam int SIZE = 1 << ADDR_BITS;

   function automatic logic [SIZE-1:0][SINE_W-1:0] build_rom();
      logic [SIZE-1:0][SINE_W-1:0] rom;
      for (int k = 0; k < SIZE; k++) begin
         rom[k] = sine_entry(k, ADDR_BITS);
      end
      return rom;
   endfunction

   localparam logic [SIZE-1:0][SINE_W-1:0] ROM = build_rom();

   logic [SINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= ROM[rd_addr];
   end

   assign rd_data = $signed(rd_data_ff);

endmodule

// File: rtl/mhsq_divider.sv
// ----------------------------------------------------------------------------
// mhsq_divider
// Restoring divider for the quantiser, one quotient bit per cycle. The
// quotient is known to fit in CODE_W bits.
// ----------------------------------------------------------------------------
module mhsq_divider
   import mhsq_pkg::*;
#(
   parameter int NUM_W = 38,
   parameter int DEN_W = 21
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic              done,
   output logic [CODE_W-1:0] quo
);

   localparam int W      = (NUM_W > DEN_W + CODE_W - 1) ? NUM_W : DEN_W + CODE_W - 1;
   localparam int STEP_W = $clog2(CODE_W);

   logic [W-1:0]      rem_ff, rem_in;
   logic [W-1:0]      dsh_ff, dsh_in;
   logic [CODE_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              fits;

   assign fits = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = W'(num);
         dsh_in  = W'(den) << (CODE_W - 1);
         quo_in  = '0;
         step_in = STEP_W'(CODE_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[CODE_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// File: rtl/multi_harmonic_synth_quantizer_core.sv
// ----------------------------------------------------------------------------
// multi_harmonic_synth_quantizer_core
// Multi-tone DDS with a uniform rounding quantiser. Harmonic entries and
// phase accumulators live in two small RAMs; a tick walks the active entries
// through a read / sine lookup / multiply / accumulate pipeline, then scales
// the sample and divides for the output code.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------
//   req     | in        | req_valid/req_stall | req_type (write or tick)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_type (sample, code)
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// a tick's result is registered after the one-entry-per-cycle RAM read
// pipeline, a multiply and a 16-step divider
// reset clears the harmonic count and the entry and accumulator valid bits,
// and loads QUANT_BITS_RESET into the quantiser bits
// req_stall is high from a tick's acceptance until its result is registered;
// a registered result waits for rsp_stall to drop while new items are taken
// ----------------------------------------------------------------------------
module multi_harmonic_synth_quantizer_core
   import mhsq_pkg::*;
#(
   parameter int MAX_HARMONICS  = MAX_HARMONICS_DEF,
   parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W  = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
   localparam int CNT_W  = $clog2(MAX_HARMONICS + 1);
   localparam int HCX_W  = (CNT_W > HC_W) ? CNT_W : HC_W;
   localparam int XI_W   = 7;
   localparam int PRD_W  = 32;
   localparam int SUM_W  = PRD_W + CNT_W;
   localparam int SMP_W  = SUM_W - 15;
   localparam int SMPX_W = (SMP_W > SAMPLE_W) ? SMP_W : SAMPLE_W;
   localparam int FULL_W = AMP_W + CNT_W;
   localparam int SF_W   = ((SMP_W > FULL_W + 1) ? SMP_W : FULL_W + 1) + 1;
   localparam int QP_W   = FULL_W + 1 + CODE_W;
   localparam int NUM_W  = QP_W + 1;
   localparam int DEN_W  = FULL_W + 1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RUN  = 6'b000010,
      ST_QMUL = 6'b000100,
      ST_QDIV = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [HC_W-1:0] hc_ff, hc_in;
   logic [QB_W-1:0] qb_ff, qb_in;
   logic [QB_W-1:0] bits_eff;
   logic [CODE_W-1:0] levels;

   // sequencing
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_sat;
   logic [CNT_W-1:0] iss_cnt_ff, iss_cnt_in;
   logic [IDX_W-1:0] iss_idx;
   logic             issue;
   logic             s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic             pipe_busy;

   logic [MAX_HARMONICS-1:0] tbl_valid_ff, tbl_valid_in;
   logic [MAX_HARMONICS-1:0] acc_valid_ff, acc_valid_in;

   // handshakes
   logic req_acc, write_acc, tick_acc, csr_acc, out_free, rsp_load;

   // write path
   logic [XI_W-1:0]  widx;
   logic             wr_in_range;
   logic [IDX_W-1:0] tbl_wr_addr;
   logic             tbl_we;

   // harmonic pipeline
   logic [TBL_W-1:0]          tbl_rd;
   logic [PHASE_W-1:0]        acc_rd;
   logic [AMP_W-1:0]          amp_b;
   logic [PHASE_W-1:0]        step_b, off_b, acc_b, phase_b, acc_next;
   logic [SINE_ADDR_BITS-1:0] rom_addr;
   logic signed [SINE_W-1:0]  sine_c;
   logic [AMP_W-1:0]          s2_amp_ff;
   logic signed [PRD_W:0]     prod_full;
   logic signed [PRD_W-1:0]   prod_ff;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [FULL_W-1:0]         full_ff, full_in;

   // quantiser
   logic signed [SMP_W-1:0]  sample_s;
   logic signed [SMPX_W-1:0] sample_x;
   logic signed [SF_W-1:0]   sf;
   logic [QP_W-1:0]          qprod_ff;
   logic                     sf_neg_ff;
   logic                     div_start, div_done;
   logic [CODE_W-1:0]        div_quo, code_c;
   logic [NUM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // ---------------------------------------------------------------- handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign write_acc = req_acc && (req_data.action == ACT_WRITE);
   assign tick_acc  = req_acc && (req_data.action == ACT_TICK);
   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == ST_OUT) && out_free;

   // ---------------------------------------------------------------- config
   always_comb begin
      hc_in = hc_ff;
      qb_in = qb_ff;
      if (csr_acc) begin
         case (csr_index)
            CSR_HARMONIC_COUNT: hc_in = csr_data[HC_W-1:0];
            CSR_QUANT_BITS:     qb_in = csr_data;
            default:            ;
         endcase
      end
   end

   assign bits_eff = (qb_ff == '0) ? QB_W'(1) :
                     (qb_ff > QUANT_BITS_MAX) ? QUANT_BITS_MAX : qb_ff;
   assign levels   = CODE_W'((17'd1 << bits_eff) - 17'd1);

   assign cnt_sat = (HCX_W'(hc_ff) > HCX_W'(MAX_HARMONICS)) ? CNT_W'(MAX_HARMONICS)
                                                             : CNT_W'(hc_ff);

   // ---------------------------------------------------------------- table write
   assign widx        = XI_W'(req_data.harmonic_index);
   assign wr_in_range = (widx < XI_W'(MAX_HARMONICS));
   assign tbl_wr_addr = widx[IDX_W-1:0];
   assign tbl_we      = write_acc && wr_in_range;

   always_comb begin
      tbl_valid_in = tbl_valid_ff;
      acc_valid_in = acc_valid_ff;
      if (tbl_we) begin
         tbl_valid_in[tbl_wr_addr] = 1'b1;
      end
      // a write restarts time: every accumulator reads as zero again
      if (write_acc) begin
         acc_valid_in = '0;
      end else if (s1_vld_ff) begin
         acc_valid_in[s1_idx_ff] = 1'b1;
      end
   end

   // ---------------------------------------------------------------- issue
   assign iss_idx   = iss_cnt_ff[IDX_W-1:0];
   assign issue     = (state_ff == ST_RUN) && (iss_cnt_ff < cnt_ff);
   assign pipe_busy = s1_vld_ff || s2_vld_ff || s3_vld_ff;

   mhsq_ram #(
      .WIDTH(TBL_W),
      .DEPTH(MAX_HARMONICS)
   ) u_tbl_ram (
      .clock  (clock),
      .wr_en  (tbl_we),
      .wr_addr(tbl_wr_addr),
      .wr_data({req_data.amplitude, req_data.phase_step, req_data.phase_offset}),
      .rd_addr(iss_idx),
      .rd_data(tbl_rd)
   );

   mhsq_ram #(
      .WIDTH(PHASE_W),
      .DEPTH(MAX_HARMONICS)
   ) u_acc_ram (
      .clock  (clock),
      .wr_en  (s1_vld_ff),
      .wr_addr(s1_idx_ff),
      .wr_data(acc_next),
      .rd_addr(iss_idx),
      .rd_data(acc_rd)
   );

   // ---------------------------------------------------------------- stage b
   // entries never written read as zero
   always_comb begin
      amp_b  = '0;
      step_b = '0;
      off_b  = '0;
      acc_b  = '0;
      if (tbl_valid_ff[s1_idx_ff]) begin
         {amp_b, step_b, off_b} = tbl_rd;
      end
      if (acc_valid_ff[s1_idx_ff]) begin
         acc_b = acc_rd;
      end
   end

   assign phase_b  = acc_b + off_b;
   assign acc_next = acc_b + step_b;
   assign rom_addr = phase_b[PHASE_W-1 -: SINE_ADDR_BITS];

   mhsq_sine_rom #(
      .ADDR_BITS(SINE_ADDR_BITS)
   ) u_sine_rom (
      .clock  (clock),
      .rd_addr(rom_addr),
      .rd_data(sine_c)
   );

   // ---------------------------------------------------------------- stages c, d
   assign prod_full = $signed({1'b0, s2_amp_ff}) * sine_c;

   always_comb begin
      sum_in  = sum_ff;
      full_in = full_ff;
      if (tick_acc) begin
         sum_in  = '0;
         full_in = '0;
      end else begin
         if (s3_vld_ff) begin
            sum_in = sum_ff + SUM_W'(prod_ff);
         end
         if (s1_vld_ff) begin
            full_in = full_ff + FULL_W'(amp_b);
         end
      end
   end

   // ---------------------------------------------------------------- quantiser
   // upper bits of the sum are the floor of sum / 2^15
   assign sample_s = $signed(sum_ff[SUM_W-1:15]);
   assign sample_x = SMPX_W'(sample_s);
   assign sf       = SF_W'(sample_s) + SF_W'($signed({1'b0, full_ff}));

   assign div_start = (state_ff == ST_QDIV);
   assign div_num   = NUM_W'(qprod_ff) + NUM_W'(full_ff);
   assign div_den   = {full_ff, 1'b0};

   mhsq_divider #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quo  (div_quo)
   );

   // zero full scale gives code zero
   assign code_c = ((full_ff == '0) || sf_neg_ff) ? '0 :
                   (div_quo > levels) ? levels : div_quo;

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      iss_cnt_in = iss_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tick_acc) begin
               cnt_in     = cnt_sat;
               iss_cnt_in = '0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue) begin
               iss_cnt_in = iss_cnt_ff + 1'b1;
            end else if (!pipe_busy) begin
               state_in = ST_QMUL;
            end
         end
         ST_QMUL: state_in = ST_QDIV;
         ST_QDIV: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hc_ff        <= '0;
         qb_ff        <= QUANT_BITS_RESET;
         tbl_valid_ff <= '0;
         acc_valid_ff <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hc_ff        <= hc_in;
         qb_ff        <= qb_in;
         tbl_valid_ff <= tbl_valid_in;
         acc_valid_ff <= acc_valid_in;
         s1_vld_ff    <= issue;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff     <= cnt_in;
      iss_cnt_ff <= iss_cnt_in;
      s1_idx_ff  <= iss_idx;
      s2_amp_ff  <= amp_b;
      prod_ff    <= $signed(prod_full[PRD_W-1:0]);
      sum_ff     <= sum_in;
      full_ff    <= full_in;
      if (state_ff == ST_QMUL) begin
         qprod_ff  <= QP_W'(sf[FULL_W:0]) * QP_W'(levels);
         sf_neg_ff <= sf[SF_W-1];
      end
      if (rsp_load) begin
         rsp_data_ff.sample <= sample_x[SAMPLE_W-1:0];
         rsp_data_ff.code   <= code_c;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   // the accumulator write-back never hits the entry being read
   a_acc_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (issue && s1_vld_ff) |-> (s1_idx_ff != iss_idx))
      else $error("accumulator read and write-back on the same entry");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (iss_cnt_ff <= cnt_ff))
      else $error("issued more harmonics than active");

   a_pipe_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QMUL) |-> !pipe_busy && (iss_cnt_ff == cnt_ff))
      else $error("quantiser started before the harmonic pipeline drained");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV) && $past(state_ff != ST_IDLE))
      else $error("divider finished outside the divide phase");

   a_code_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.code <= levels))
      else $error("output code above the level count");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-harmonic synthesiser and quantiser. A
// queue-fed driver sends harmonic writes and ticks in bursts, the receiver
// stalls on a pattern of its own, and every tick's sample and code are
// predicted from a local copy of the harmonic table, the phase accumulators
// and the configuration, then checked against the DUT's output transactions.
// ----------------------------------------------------------------------------
module tb_top
   import mhsq_pkg::*;
();

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 12;
   localparam int DRAIN_CYCLES   = 40;
   localparam int TIMEOUT_CYCLES = 1500000;
   localparam int NUM_PHASES     = 12;
   localparam int PHASE_ITEMS    = 127;
   localparam int LUT_BITS       = SINE_ADDR_BITS_DEF;
   localparam int LUT_SIZE       = 1 << LUT_BITS;
   localparam int LUT_QTR        = LUT_SIZE / 4;
   localparam int N_TONES        = MAX_HARMONICS_DEF;
   localparam int MAX_PRINTS     = 50;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_QUANT_BITS + 1'b1;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // local copy of the synthesiser state
   logic [AMP_W-1:0]   tone_amp    [N_TONES];
   logic [PHASE_W-1:0] tone_step   [N_TONES];
   logic [PHASE_W-1:0] tone_offset [N_TONES];
   logic [PHASE_W-1:0] tone_phase  [N_TONES];
   logic [HC_W-1:0]    tone_count;
   logic [QB_W-1:0]    code_bits;
   int                 sine_lut    [LUT_SIZE];

   req_type synth_items[$];
   rsp_type samples_due[$];
   int      error_count = 0;
   int      burst_left  = 0;
   int      gap_left    = 0;
   int      stall_left  = 0;

   multi_harmonic_synth_quantizer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("tb_top: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // applies one accepted transaction to the local state; a tick queues its
   // expected sample and code
   task automatic synth_apply(input req_type item);
      longint      acc_sum;
      longint      full;
      longint      smp;
      longint      levels;
      longint      num;
      longint      code_v;
      int unsigned cnt;
      int unsigned bits;
      logic [PHASE_W-1:0] ph;
      rsp_type     want;
      acc_sum = 0;
      full    = 0;
      if (item.action == ACT_WRITE) begin
         tone_amp[item.harmonic_index]    = item.amplitude;
         tone_step[item.harmonic_index]   = item.phase_step;
         tone_offset[item.harmonic_index] = item.phase_offset;
         for (int i = 0; i < N_TONES; i++) tone_phase[i] = '0;
      end else begin
         cnt = (tone_count > N_TONES) ? N_TONES : tone_count;
         for (int i = 0; i < cnt; i++) begin
            ph      = tone_phase[i] + tone_offset[i];
            acc_sum += longint'(tone_amp[i]) * sine_lut[ph[PHASE_W-1 -: LUT_BITS]];
            full    += longint'(tone_amp[i]);
            tone_phase[i] = tone_phase[i] + tone_step[i];
         end
         // arithmetic shift floors negative sums
         smp  = acc_sum >>> 15;
         bits = (code_bits < 1) ? 1 : (code_bits > QUANT_BITS_MAX) ? QUANT_BITS_MAX : code_bits;
         levels = (64'sd1 << bits) - 1;
         if (full == 0) begin
            code_v = 0;
         end else begin
            num    = (smp + full) * levels + full;
            code_v = (num < 0) ? 0 : num / (2 * full);
            if (code_v > levels) code_v = levels;
         end
         want.sample = smp[SAMPLE_W-1:0];
         want.code   = code_v[CODE_W-1:0];
         samples_due.insert(samples_due.size(), want);
      end
   endtask

   // driver: bursts of transactions with random gaps in between
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) synth_apply(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (synth_items.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= synth_items.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 23);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with quiet stretches now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         stall_left = $urandom_range(1, 30);
         case ($urandom_range(0, 4))
            0, 1: begin
               rsp_stall <= 1'b1;
            end
            2: begin
               rsp_stall  <= 1'b0;
               stall_left = $urandom_range(100, 300);
            end
            default: begin
               rsp_stall <= 1'b0;
            end
         endcase
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (samples_due.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction sample %0d code %0d",
                                      $signed(rsp_data.sample), rsp_data.code));
         end else begin
            want = samples_due.pop_front();
            if (rsp_data.sample !== want.sample) begin
               report_mismatch($sformatf("sample got %0d want %0d",
                                         $signed(rsp_data.sample), $signed(want.sample)));
            end
            if (rsp_data.code !== want.code) begin
               report_mismatch($sformatf("code got %0d want %0d", rsp_data.code, want.code));
            end
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_HARMONIC_COUNT) tone_count = val[HC_W-1:0];
      else if (idx == CSR_QUANT_BITS) code_bits = val[QB_W-1:0];
   endtask

   // a write gives no result, so allow the block to finish after the last one
   task automatic wait_drained();
      while (synth_items.size() != 0 || req_valid || samples_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] count_val,
                            input logic [CSR_DATA_W-1:0] bits_val);
      wait_drained();
      csr_write(CSR_HARMONIC_COUNT, count_val);
      csr_write(CSR_QUANT_BITS, bits_val);
      if ($urandom_range(0, 1)) begin
         csr_write(CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, (1 << CSR_IDX_W) - 1)),
                   CSR_DATA_W'($urandom));
      end
   endtask

   function automatic void queue_write(input int idx, input logic [AMP_W-1:0] amp,
                                       input logic [PHASE_W-1:0] step,
                                       input logic [PHASE_W-1:0] offs);
      req_type item;
      item.action         = ACT_WRITE;
      item.harmonic_index = HIDX_W'(idx);
      item.amplitude      = amp;
      item.phase_step     = step;
      item.phase_offset   = offs;
      synth_items.insert(synth_items.size(), item);
   endfunction

   // fields other than the action are don't-care on a tick
   function automatic void queue_tick();
      req_type item;
      item.action         = ACT_TICK;
      item.harmonic_index = HIDX_W'($urandom);
      item.amplitude      = AMP_W'($urandom);
      item.phase_step     = $urandom;
      item.phase_offset   = $urandom;
      synth_items.insert(synth_items.size(), item);
   endfunction

   function automatic void queue_random_write(input int idx);
      logic [AMP_W-1:0]   amp;
      logic [PHASE_W-1:0] step;
      logic [PHASE_W-1:0] offs;
      case ($urandom_range(0, 7))
         0:       amp = '0;
         1:       amp = '1;
         default: amp = AMP_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0:       step = '0;
         1:       step = '1;
         2, 3:    step = $urandom_range(0, 1 << 24);
         default: step = $urandom;
      endcase
      case ($urandom_range(0, 7))
         0:       offs = '0;
         1:       offs = '1;
         default: offs = $urandom;
      endcase
      queue_write(idx, amp, step, offs);
   endfunction

   initial begin
      int unsigned        q;
      int unsigned        m;
      longint unsigned    x;
      longint unsigned    x2;
      longint unsigned    term;
      longint             s;
      longint             v;
      logic [CSR_DATA_W-1:0] count_val;
      logic [CSR_DATA_W-1:0] bits_val;

      // q1.15 sine: taylor series in q30 over one quadrant, mirrored
      for (int k = 0; k < LUT_SIZE; k++) begin
         q    = k / LUT_QTR;
         m    = (q == 0 || q == 2) ? (k % LUT_QTR) : LUT_QTR - (k % LUT_QTR);
         x    = (longint'(m) * HALF_PI_Q30 + LUT_QTR / 2) / LUT_QTR;
         x2   = (x * x) >> 30;
         term = x;
         s    = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2) s -= longint'(term);
            else s += longint'(term);
         end
         if (s < 0) s = 0;
         if (s > ONE_Q30) s = ONE_Q30;
         v = (s * 32767 + (64'sd1 << 29)) >>> 30;
         sine_lut[k] = (q >= 2) ? -int'(v) : int'(v);
      end
      for (int i = 0; i < N_TONES; i++) begin
         tone_amp[i]    = '0;
         tone_step[i]   = '0;
         tone_offset[i] = '0;
         tone_phase[i]  = '0;
      end
      tone_count = '0;
      code_bits  = QUANT_BITS_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // zero harmonic count straight after reset
      queue_tick();
      queue_write(0, '0, '0, '0);
      queue_tick();

      // all entries at full amplitude, positive then negative peak
      configure(5'd8, 5'd16);
      for (int i = 0; i < N_TONES; i++) queue_write(i, '1, '0, 32'h4000_0000);
      queue_tick();
      queue_tick();
      for (int i = 0; i < N_TONES; i++) queue_write(i, '1, '1, 32'hC000_0000);
      queue_tick();
      queue_tick();

      // zero full scale, and a zero resolution that counts as one bit
      configure(5'd1, 5'd0);
      queue_write(0, '0, '1, '1);
      queue_tick();
      queue_write(0, '1, 32'h0100_0000, '0);
      queue_tick();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin count_val = 5'd31; bits_val = 5'd31; end
            1: begin count_val = 5'd1;  bits_val = 5'd1;  end
            2: begin count_val = 5'd8;  bits_val = 5'd17; end
            3: begin count_val = 5'd16; bits_val = 5'd8;  end
            default: begin
               count_val = ($urandom_range(0, 5) == 0) ? CSR_DATA_W'($urandom)
                                                        : CSR_DATA_W'($urandom_range(1, 8));
               bits_val  = CSR_DATA_W'($urandom);
            end
         endcase
         configure(count_val, bits_val);
         // fill the whole table, then mostly ticks with the odd rewrite
         for (int i = 0; i < N_TONES; i++) queue_random_write(i);
         for (int j = 0; j < PHASE_ITEMS; j++) begin
            if ($urandom_range(0, 9) == 0) queue_random_write($urandom_range(0, N_TONES - 1));
            else queue_tick();
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
